FILE: sv/frie_pkg.sv
package frie_pkg;

    localparam int unsigned DATA_W            = 32;
    localparam int unsigned LINE_W            = 8;
    localparam int unsigned MAX_PROGRAM_LINES = 128;
    localparam int unsigned NUM_REGS          = 4;
    localparam int unsigned REG_AW            = $clog2(NUM_REGS);
    localparam int unsigned PADDR_W           = 3;
    localparam int unsigned ALU_STEPS         = DATA_W;
    localparam int unsigned STEP_W            = $clog2(ALU_STEPS);

    localparam logic [LINE_W-1:0] MAX_LINES  = LINE_W'(MAX_PROGRAM_LINES);
    localparam logic [DATA_W-1:0] DATA_MIN   = {1'b1, {(DATA_W-1){1'b0}}};

    // Register index, taken from paddr above the byte offset
    localparam logic [PADDR_W-3:0] REG_PROGRAM_LENGTH = '0;

    typedef enum logic [3:0] {
        CMD_MOV   = 4'd0,
        CMD_ADD   = 4'd1,
        CMD_SUB   = 4'd2,
        CMD_MUL   = 4'd3,
        CMD_DIV   = 4'd4,
        CMD_JMP   = 4'd5,
        CMD_JE    = 4'd6,
        CMD_JNE   = 4'd7,
        CMD_JG    = 4'd8,
        CMD_JGE   = 4'd9,
        CMD_JL    = 4'd10,
        CMD_JLE   = 4'd11,
        CMD_READ  = 4'd12,
        CMD_PRINT = 4'd13,
        CMD_NOP   = 4'd14
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_RD_C,
        S_EXEC,
        S_ITER,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        U_IDLE,
        U_MUL,
        U_DIV,
        U_FIX,
        U_DONE
    } alu_state_t;

    typedef struct packed {
        logic start;
        logic div;
    } alu_ctl_t;

    typedef struct packed {
        logic [3:0]              cmd;
        logic                    first_is_reg;
        logic [REG_AW-1:0]       first_reg;
        logic signed [DATA_W-1:0] first_imm;
        logic                    second_is_reg;
        logic [REG_AW-1:0]       second_reg;
        logic signed [DATA_W-1:0] second_imm;
        logic                    third_is_reg;
        logic [REG_AW-1:0]       third_reg;
        logic signed [DATA_W-1:0] third_imm;
        logic signed [DATA_W-1:0] read_value;
    } item_t;

    typedef struct packed {
        logic [LINE_W-1:0]        next_line;
        logic                     halted;
        logic                     print_valid;
        logic signed [DATA_W-1:0] print_value;
        logic                     divide_fault;
    } result_t;

endpackage

FILE: sv/frie_if.sv
interface frie_in_if;
    logic                                valid;
    logic                                ready;
    logic [3:0]                          cmd;
    logic                                first_is_reg;
    logic [frie_pkg::REG_AW-1:0]         first_reg;
    logic signed [frie_pkg::DATA_W-1:0]  first_imm;
    logic                                second_is_reg;
    logic [frie_pkg::REG_AW-1:0]         second_reg;
    logic signed [frie_pkg::DATA_W-1:0]  second_imm;
    logic                                third_is_reg;
    logic [frie_pkg::REG_AW-1:0]         third_reg;
    logic signed [frie_pkg::DATA_W-1:0]  third_imm;
    logic signed [frie_pkg::DATA_W-1:0]  read_value;

    modport source (
        output valid, cmd, first_is_reg, first_reg, first_imm,
               second_is_reg, second_reg, second_imm,
               third_is_reg, third_reg, third_imm, read_value,
        input  ready
    );

    modport sink (
        input  valid, cmd, first_is_reg, first_reg, first_imm,
               second_is_reg, second_reg, second_imm,
               third_is_reg, third_reg, third_imm, read_value,
        output ready
    );
endinterface

interface frie_out_if;
    logic                                valid;
    logic                                ready;
    logic [frie_pkg::LINE_W-1:0]         next_line;
    logic                                halted;
    logic                                print_valid;
    logic signed [frie_pkg::DATA_W-1:0]  print_value;
    logic                                divide_fault;

    modport source (
        output valid, next_line, halted, print_valid, print_value, divide_fault,
        input  ready
    );

    modport sink (
        input  valid, next_line, halted, print_valid, print_value, divide_fault,
        output ready
    );
endinterface

FILE: sv/frie_alu.sv
module frie_alu (
    input  logic                          clk,
    input  logic                          rst_n,
    input  frie_pkg::alu_ctl_t            ctl,
    input  logic [frie_pkg::DATA_W-1:0]   opa,
    input  logic [frie_pkg::DATA_W-1:0]   opb,
    input  logic                          sub,
    output logic [frie_pkg::DATA_W:0]     sum,
    output logic                          done,
    output logic [frie_pkg::DATA_W-1:0]   result
);

    frie_pkg::alu_state_t ust_reg, ust_next;
    logic [frie_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic [frie_pkg::DATA_W-1:0] w0_reg, w0_next;
    logic [frie_pkg::DATA_W-1:0] w1_reg, w1_next;
    logic [frie_pkg::DATA_W-1:0] w2_reg, w2_next;
    logic                        neg_reg, neg_next;

    logic [frie_pkg::DATA_W-1:0] add_x, add_y, div_x, abs_a, abs_b;
    logic                        add_cin, last_step;

    assign last_step = (cnt_reg == frie_pkg::STEP_W'(frie_pkg::ALU_STEPS - 1));
    assign div_x     = {w0_reg[frie_pkg::DATA_W-2:0], w2_reg[frie_pkg::DATA_W-1]};
    assign abs_a     = opa[frie_pkg::DATA_W-1] ? (~opa + 1'b1) : opa;
    assign abs_b     = opb[frie_pkg::DATA_W-1] ? (~opb + 1'b1) : opb;

    // One adder serves quick ops, multiply steps, divide steps and the sign fix
    always_comb
    begin
        case (ust_reg)
            frie_pkg::U_MUL:
            begin
                add_x   = w0_reg;
                add_y   = w1_reg;
                add_cin = 1'b0;
            end
            frie_pkg::U_DIV:
            begin
                add_x   = div_x;
                add_y   = ~w1_reg;
                add_cin = 1'b1;
            end
            frie_pkg::U_FIX:
            begin
                add_x   = '0;
                add_y   = ~w2_reg;
                add_cin = 1'b1;
            end
            default:
            begin
                add_x   = opa;
                add_y   = sub ? ~opb : opb;
                add_cin = sub;
            end
        endcase
    end

    assign sum = {1'b0, add_x} + {1'b0, add_y} + (frie_pkg::DATA_W+1)'(add_cin);

    always_comb
    begin
        case (ust_reg)
            frie_pkg::U_IDLE:
            begin
                if (ctl.start)
                    ust_next = ctl.div ? frie_pkg::U_DIV : frie_pkg::U_MUL;
                else
                    ust_next = frie_pkg::U_IDLE;
            end
            frie_pkg::U_MUL: ust_next = last_step ? frie_pkg::U_DONE : frie_pkg::U_MUL;
            frie_pkg::U_DIV: ust_next = last_step ? frie_pkg::U_FIX : frie_pkg::U_DIV;
            frie_pkg::U_FIX: ust_next = frie_pkg::U_DONE;
            default:         ust_next = frie_pkg::U_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        w0_next  = w0_reg;
        w1_next  = w1_reg;
        w2_next  = w2_reg;
        neg_next = neg_reg;
        case (ust_reg)
            frie_pkg::U_IDLE:
            begin
                if (ctl.start)
                begin
                    cnt_next = '0;
                    w0_next  = '0;
                    w1_next  = ctl.div ? abs_b : opa;
                    w2_next  = ctl.div ? abs_a : opb;
                    neg_next = opa[frie_pkg::DATA_W-1] ^ opb[frie_pkg::DATA_W-1];
                end
            end
            frie_pkg::U_MUL:
            begin
                if (w2_reg[0])
                    w0_next = sum[frie_pkg::DATA_W-1:0];
                w1_next  = {w1_reg[frie_pkg::DATA_W-2:0], 1'b0};
                w2_next  = {1'b0, w2_reg[frie_pkg::DATA_W-1:1]};
                cnt_next = cnt_reg + 1'b1;
            end
            frie_pkg::U_DIV:
            begin
                // restore when the trial subtract borrows
                w0_next  = sum[frie_pkg::DATA_W] ? sum[frie_pkg::DATA_W-1:0] : div_x;
                w2_next  = {w2_reg[frie_pkg::DATA_W-2:0], sum[frie_pkg::DATA_W]};
                cnt_next = cnt_reg + 1'b1;
            end
            frie_pkg::U_FIX:
            begin
                w0_next = neg_reg ? sum[frie_pkg::DATA_W-1:0] : w2_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ust_reg <= frie_pkg::U_IDLE;
        else
            ust_reg <= ust_next;
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        w0_reg  <= w0_next;
        w1_reg  <= w1_next;
        w2_reg  <= w2_next;
        neg_reg <= neg_next;
    end

    assign done   = (ust_reg == frie_pkg::U_DONE);
    assign result = w0_reg;

endmodule

FILE: sv/four_register_instruction_executor_top.sv
// Executes one decoded instruction per request against four 32-bit registers
// (ax, bx, cx, dx) and a line counter.
// in_ch carries the instruction (command, three operands, read value); out_ch
// returns one result per request: next line, halted flag, print value and
// divide fault. The APB port holds program_length at address 0.
// The register file is a 4-entry memory with one registered read port, so the
// three operands are fetched in turn (S_RD_A, S_RD_B, S_RD_C); a single adder
// does add, sub, compares and every step of the shift-add multiply and restoring
// divide. Mul takes 32 steps of the shared adder; div takes 32 steps plus a
// sign fix.
// A new request is taken only in idle, after the result has been loaded into the
// output register; the block cannot take a request while one is in progress.
// A result waiting on out_ch does not block the next request; a second result
// waits inside until the output register frees up.
// Reset marks all registers unwritten, so they read as zero, clears the line
// counter to zero and sets program_length to 128; no clearing pass is needed.
// Once halted, requests are still taken and answered with halted set.
module four_register_instruction_executor_top (
    input  logic                           clk,
    input  logic                           rst_n,
    frie_in_if.sink                        in_ch,
    frie_out_if.source                     out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [frie_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int unsigned DW = frie_pkg::DATA_W;
    localparam int unsigned LW = frie_pkg::LINE_W;

    frie_pkg::state_t  state_reg, state_next;
    frie_pkg::item_t   item_reg;
    frie_pkg::result_t res_reg, res_next, out_reg;
    frie_pkg::cmd_t    cmd;
    frie_pkg::alu_ctl_t alu_ctl;

    logic          halt_reg;
    logic [DW-1:0] op_a_reg, op_a_next, op_b_reg, op_b_next;
    logic [LW-1:0] lc_reg, lc_next, plen_reg, eff_len;
    logic          out_valid_reg, out_valid_next;

    logic [DW-1:0] regs_mem [frie_pkg::NUM_REGS];
    logic [frie_pkg::NUM_REGS-1:0] regvld_reg;
    logic [DW-1:0] rd_data_reg;
    logic          rd_vld_reg;
    logic [frie_pkg::REG_AW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    logic [DW-1:0] wr_data, rd_val, op_c;

    logic [DW-1:0] alu_opa, alu_opb, alu_result;
    logic [DW:0]   alu_sum;
    logic          alu_sub, alu_done;

    logic          take_in, cfg_hit, out_load;
    logic          b_ge_c, b_eq_c, jump, div_fault, long_op;
    logic [LW-1:0] seq_line, jmp_line, exec_line;

    assign cmd     = frie_pkg::cmd_t'(item_reg.cmd);
    assign take_in = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == frie_pkg::S_IDLE);
    assign out_load = (state_reg == frie_pkg::S_DONE) && (!out_valid_reg || out_ch.ready);

    // APB register access
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[frie_pkg::PADDR_W-1:2] == frie_pkg::REG_PROGRAM_LENGTH);
    assign prdata  = cfg_hit ? {{(32-LW){1'b0}}, plen_reg} : '0;

    always_comb
    begin
        if (plen_reg == '0)
            eff_len = LW'(1);
        else if (plen_reg > frie_pkg::MAX_LINES)
            eff_len = frie_pkg::MAX_LINES;
        else
            eff_len = plen_reg;
    end

    // Register file: entries never written read as zero
    assign rd_val = rd_vld_reg ? rd_data_reg : '0;
    assign op_c   = item_reg.third_is_reg ? rd_val : item_reg.third_imm;

    always_ff @(posedge clk)
    begin
        rd_data_reg <= regs_mem[rd_addr];
        if (wr_en)
            regs_mem[wr_addr] <= wr_data;
    end

    // Shared adder operands
    always_comb
    begin
        case (cmd)
            frie_pkg::CMD_ADD, frie_pkg::CMD_MUL, frie_pkg::CMD_DIV:
            begin
                alu_opa = op_a_reg;
                alu_opb = op_b_reg;
                alu_sub = 1'b0;
            end
            frie_pkg::CMD_SUB:
            begin
                alu_opa = op_b_reg;
                alu_opb = op_a_reg;
                alu_sub = 1'b1;
            end
            default:
            begin
                // signed compare: flip sign bits, then unsigned subtract
                alu_opa = op_b_reg ^ frie_pkg::DATA_MIN;
                alu_opb = op_c ^ frie_pkg::DATA_MIN;
                alu_sub = 1'b1;
            end
        endcase
    end

    frie_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (alu_ctl),
        .opa    (alu_opa),
        .opb    (alu_opb),
        .sub    (alu_sub),
        .sum    (alu_sum),
        .done   (alu_done),
        .result (alu_result)
    );

    assign b_ge_c = alu_sum[DW];
    assign b_eq_c = (op_b_reg == op_c);

    always_comb
    begin
        case (cmd)
            frie_pkg::CMD_JMP: jump = 1'b1;
            frie_pkg::CMD_JE:  jump = b_eq_c;
            frie_pkg::CMD_JNE: jump = !b_eq_c;
            frie_pkg::CMD_JG:  jump = b_ge_c && !b_eq_c;
            frie_pkg::CMD_JGE: jump = b_ge_c;
            frie_pkg::CMD_JL:  jump = !b_ge_c;
            frie_pkg::CMD_JLE: jump = !b_ge_c || b_eq_c;
            default:           jump = 1'b0;
        endcase
    end

    assign div_fault = (cmd == frie_pkg::CMD_DIV) &&
                       ((op_b_reg == '0) ||
                        ((op_a_reg == frie_pkg::DATA_MIN) && (op_b_reg == '1)));
    assign long_op   = (cmd == frie_pkg::CMD_MUL) ||
                       ((cmd == frie_pkg::CMD_DIV) && !div_fault);

    assign seq_line  = lc_reg + 1'b1;
    assign jmp_line  = ((op_a_reg[DW-1:LW] != '0) || (op_a_reg[LW-1:0] >= eff_len)) ?
                       eff_len : op_a_reg[LW-1:0];
    assign exec_line = jump ? jmp_line : seq_line;

    // Next state
    always_comb
    begin
        case (state_reg)
            frie_pkg::S_IDLE: state_next = take_in ? frie_pkg::S_RD_A : frie_pkg::S_IDLE;
            frie_pkg::S_RD_A: state_next = halt_reg ? frie_pkg::S_DONE : frie_pkg::S_RD_B;
            frie_pkg::S_RD_B: state_next = frie_pkg::S_RD_C;
            frie_pkg::S_RD_C: state_next = frie_pkg::S_EXEC;
            frie_pkg::S_EXEC: state_next = long_op ? frie_pkg::S_ITER : frie_pkg::S_DONE;
            frie_pkg::S_ITER: state_next = alu_done ? frie_pkg::S_DONE : frie_pkg::S_ITER;
            frie_pkg::S_DONE: state_next = out_load ? frie_pkg::S_IDLE : frie_pkg::S_DONE;
            default:          state_next = frie_pkg::S_IDLE;
        endcase
    end

    // Datapath control
    always_comb
    begin
        rd_addr   = item_reg.first_reg;
        wr_en     = 1'b0;
        wr_addr   = item_reg.second_reg;
        wr_data   = alu_sum[DW-1:0];
        op_a_next = op_a_reg;
        op_b_next = op_b_reg;
        lc_next   = lc_reg;
        res_next  = res_reg;
        alu_ctl   = '0;
        case (state_reg)
            frie_pkg::S_RD_A:
            begin
                if (halt_reg)
                begin
                    res_next           = '0;
                    res_next.next_line = lc_reg;
                    res_next.halted    = 1'b1;
                end
            end
            frie_pkg::S_RD_B:
            begin
                op_a_next = item_reg.first_is_reg ? rd_val : item_reg.first_imm;
                rd_addr   = item_reg.second_reg;
            end
            frie_pkg::S_RD_C:
            begin
                op_b_next = item_reg.second_is_reg ? rd_val : item_reg.second_imm;
                rd_addr   = item_reg.third_reg;
            end
            frie_pkg::S_EXEC:
            begin
                if (long_op)
                begin
                    alu_ctl.start = 1'b1;
                    alu_ctl.div   = (cmd == frie_pkg::CMD_DIV);
                end
                else
                begin
                    lc_next               = exec_line;
                    res_next.next_line    = exec_line;
                    res_next.halted       = (exec_line >= eff_len);
                    res_next.print_valid  = (cmd == frie_pkg::CMD_PRINT);
                    res_next.print_value  = (cmd == frie_pkg::CMD_PRINT) ? op_a_reg : '0;
                    res_next.divide_fault = div_fault;
                    case (cmd)
                        frie_pkg::CMD_MOV:
                        begin
                            wr_en   = item_reg.second_is_reg;
                            wr_data = op_a_reg;
                        end
                        frie_pkg::CMD_ADD, frie_pkg::CMD_SUB:
                        begin
                            wr_en = item_reg.second_is_reg;
                        end
                        frie_pkg::CMD_READ:
                        begin
                            wr_en   = item_reg.first_is_reg;
                            wr_addr = item_reg.first_reg;
                            wr_data = item_reg.read_value;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            frie_pkg::S_ITER:
            begin
                if (alu_done)
                begin
                    wr_en              = item_reg.second_is_reg;
                    wr_data            = alu_result;
                    lc_next            = seq_line;
                    res_next           = '0;
                    res_next.next_line = seq_line;
                    res_next.halted    = (seq_line >= eff_len);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= frie_pkg::S_IDLE;
            lc_reg        <= '0;
            plen_reg      <= frie_pkg::MAX_LINES;
            out_valid_reg <= 1'b0;
            regvld_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            halt_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lc_reg        <= lc_next;
            out_valid_reg <= out_valid_next;
            rd_vld_reg    <= regvld_reg[rd_addr];
            if (wr_en)
                regvld_reg[wr_addr] <= 1'b1;
            if (take_in)
                halt_reg <= (lc_reg >= eff_len);
            if (psel && penable && pwrite && cfg_hit)
                plen_reg <= pwdata[LW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        op_a_reg <= op_a_next;
        op_b_reg <= op_b_next;
        res_reg  <= res_next;
        if (out_load)
            out_reg <= res_reg;
        if (take_in)
        begin
            item_reg.cmd           <= in_ch.cmd;
            item_reg.first_is_reg  <= in_ch.first_is_reg;
            item_reg.first_reg     <= in_ch.first_reg;
            item_reg.first_imm     <= in_ch.first_imm;
            item_reg.second_is_reg <= in_ch.second_is_reg;
            item_reg.second_reg    <= in_ch.second_reg;
            item_reg.second_imm    <= in_ch.second_imm;
            item_reg.third_is_reg  <= in_ch.third_is_reg;
            item_reg.third_reg     <= in_ch.third_reg;
            item_reg.third_imm     <= in_ch.third_imm;
            item_reg.read_value    <= in_ch.read_value;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.next_line    = out_reg.next_line;
    assign out_ch.halted       = out_reg.halted;
    assign out_ch.print_valid  = out_reg.print_valid;
    assign out_ch.print_value  = out_reg.print_value;
    assign out_ch.divide_fault = out_reg.divide_fault;

endmodule

FILE: sv/frie_checker.sv
module frie_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [frie_pkg::LINE_W-1:0]        next_line,
    input logic                               halted,
    input logic                               print_valid,
    input logic signed [frie_pkg::DATA_W-1:0] print_value,
    input logic                               divide_fault
);

    // Hold a stalled result: next_line, halted, print_value and divide_fault stay unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(next_line) && $stable(halted)
            && $stable(print_value) && $stable(divide_fault))
        else $error("stalled result changed");

    // One request in flight: ready drops right after an accept
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while busy");

    a_print_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !print_valid |-> print_value == '0)
        else $error("print value without print");

    a_fault_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_fault |-> !print_valid)
        else $error("divide fault on a print");

    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !halted |-> next_line < frie_pkg::MAX_LINES)
        else $error("running line beyond program limit");

endmodule

bind four_register_instruction_executor_top frie_checker u_frie_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .next_line    (out_ch.next_line),
    .halted       (out_ch.halted),
    .print_valid  (out_ch.print_valid),
    .print_value  (out_ch.print_value),
    .divide_fault (out_ch.divide_fault)
);
